[hdl/gbr_pkg.sv]
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types and constants of the 9x9 RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gbr_pkg;

  // One RGB pixel as stored in the row store.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } gbr_pix_t;

  localparam int WEIGHT_W    = 16;
  localparam int NUM_WEIGHTS = 5;
  localparam int WI_W        = 3;
  localparam int DC_W        = 4;
  localparam int CSUM_W      = 28;
  localparam int ACC_W       = 48;
  localparam int FRAC_W      = 32;
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = 4;
  localparam int CFG_W       = 12;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] gbr_weights_t;

  // Column sums of the three channels.
  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } gbr_csum_t;

  // Control that travels with one column of the kernel.
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [DC_W-1:0] dc;
  } gbr_tag_t;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_WEIGHT0 = 3'd2,
    REG_WEIGHT1 = 3'd3,
    REG_WEIGHT2 = 3'd4,
    REG_WEIGHT3 = 3'd5,
    REG_WEIGHT4 = 3'd6
  } gbr_reg_t;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd512;
  localparam gbr_weights_t WEIGHT_RST = {16'd1810, 16'd4344, 16'd8116, 16'd11810, 16'd13376};

endpackage

[hdl/gbr_if.sv]
// ----------------------------------------------------------------------------
// gbr_in_if / gbr_out_if
// Valid/ready channels for input pixels and blurred result pixels.
// ----------------------------------------------------------------------------
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

[hdl/gaussian_blur_rgb_9x9.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_9x9
// Separable 9x9 Gaussian blur of a raster RGB stream with edge clamping.
// ----------------------------------------------------------------------------
// An item that yields no result (the first rows and columns of a frame, or
// an ignored drain) leaves the block idle. An item that yields a result holds
// off input until that result is loaded for output: the kernel columns are
// read one per cycle through the shared column read port of the row store,
// then pass the row cell chain, the column multiplier and the accumulator.
// Results follow the input by KERNEL_WIDTH/2 rows and columns; after the
// last pixel, drain items release the remaining results of the frame.
module gaussian_blur_rgb_9x9 import gbr_pkg::*; #(
  parameter int KERNEL_WIDTH = 9,
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_HEIGHT   = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  gbr_in_if.sink              in_if,
  gbr_out_if.source           out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int HALF  = KERNEL_WIDTH / 2;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + KERNEL_WIDTH);
  localparam int PW    = ROW_W + COL_W;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_LOAD} state_t;

  // Configuration registers.
  logic [CFG_W-1:0] width_cfg_r, height_cfg_r;
  gbr_weights_t     weights_r;
  logic             cfg_wr, cfg_restart;
  gbr_reg_t         cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = gbr_reg_t'(paddr[PADDR_W-1:2]);
  assign cfg_restart = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
      weights_r    <= WEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:   width_cfg_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT:  height_cfg_r <= pwdata[CFG_W-1:0];
        REG_WEIGHT0: weights_r[0] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT1: weights_r[1] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT2: weights_r[2] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT3: weights_r[3] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT4: weights_r[4] <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:   prdata = PDATA_W'(width_cfg_r);
      REG_HEIGHT:  prdata = PDATA_W'(height_cfg_r);
      REG_WEIGHT0: prdata = PDATA_W'(weights_r[0]);
      REG_WEIGHT1: prdata = PDATA_W'(weights_r[1]);
      REG_WEIGHT2: prdata = PDATA_W'(weights_r[2]);
      REG_WEIGHT3: prdata = PDATA_W'(weights_r[3]);
      REG_WEIGHT4: prdata = PDATA_W'(weights_r[4]);
      default:     prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize as the maximum.
  logic [COL_W-1:0] w_eff, wm1;
  logic [ROW_W-1:0] h_eff, hm1;
  logic [PW-1:0]    lag;

  always_comb begin
    if (width_cfg_r == '0) w_eff = COL_W'(1);
    else if (32'(width_cfg_r) > MAX_WIDTH) w_eff = COL_W'(MAX_WIDTH);
    else w_eff = COL_W'(width_cfg_r);
    if (height_cfg_r == '0) h_eff = ROW_W'(1);
    else if (32'(height_cfg_r) > MAX_HEIGHT) h_eff = ROW_W'(MAX_HEIGHT);
    else h_eff = ROW_W'(height_cfg_r);
  end

  assign wm1 = w_eff - COL_W'(1);
  assign hm1 = h_eff - ROW_W'(1);
  assign lag = PW'(HALF) * PW'(w_eff) + PW'(HALF);

  // Control state.
  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [DC_W-1:0]   dc_cnt_r, dc_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_red_r, out_green_r, out_blue_r;
  logic              out_last_r;
  logic              in_acc, frame_in, emit, last_now, out_load, acc_done;
  logic [7:0]        acc_red, acc_green, acc_blue;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign frame_in    = in_row_r < h_eff;
  assign emit        = p_r >= lag;
  assign last_now    = (out_row_r >= hm1) && (out_col_r >= wm1);
  assign out_load    = (state_r == S_LOAD) && (!out_valid_r || out_if.ready);

  // Sequencer and raster counters.
  always_comb begin
    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    p_nxt       = p_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    dc_cnt_nxt  = dc_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !(in_if.action && frame_in)) begin
          p_nxt = p_r + PW'(1);
          if (in_col_r + COL_W'(1) >= w_eff) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + ROW_W'(1);
          end else begin
            in_col_nxt = in_col_r + COL_W'(1);
          end
          if (emit) begin
            state_nxt  = S_READ;
            dc_cnt_nxt = '0;
          end
        end
      end
      S_READ: begin
        dc_cnt_nxt = dc_cnt_r + DC_W'(1);
        if (dc_cnt_r == DC_W'(KERNEL_WIDTH - 1)) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (acc_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
          if (last_now) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            p_nxt       = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (out_col_r + COL_W'(1) >= w_eff) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + ROW_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
        end
      end
    endcase
    // A new frame size restarts the frame.
    if (cfg_restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      p_nxt       = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      p_r         <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      dc_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      p_r         <= p_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      dc_cnt_r    <= dc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_red_r   <= acc_red;
      out_green_r <= acc_green;
      out_blue_r  <= acc_blue;
      out_last_r  <= last_now;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_red    = out_red_r;
  assign out_if.out_green  = out_green_r;
  assign out_if.out_blue   = out_blue_r;
  assign out_if.frame_last = out_last_r;

  // Clamped column of the kernel column being read.
  logic [COL_W:0]   col_sum, col_off;
  logic [COL_W-1:0] rd_col;

  assign col_sum = (COL_W+1)'(out_col_r) + (COL_W+1)'(dc_cnt_r);
  assign col_off = col_sum - (COL_W+1)'(HALF);
  always_comb begin
    if (col_sum < (COL_W+1)'(HALF)) rd_col = '0;
    else if (col_off > (COL_W+1)'(wm1)) rd_col = wm1;
    else rd_col = col_off[COL_W-1:0];
  end

  // Row store.
  gbr_pix_t             wr_pix;
  gbr_pix_t [SLOTS-1:0] bank_q;

  assign wr_pix = '{red: in_if.in_red, green: in_if.in_green, blue: in_if.in_blue};

  gbr_row_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk     (clk),
    .wr_en   (in_acc && !in_if.action && frame_in),
    .wr_slot (in_row_r[SLOT_W-1:0]),
    .wr_col  (in_col_r[AW-1:0]),
    .wr_data (wr_pix),
    .rd_col  (rd_col[AW-1:0]),
    .rd_data (bank_q)
  );

  // Clamped row of every kernel row, and its ring slot.
  gbr_pix_t [KERNEL_WIDTH-1:0] col_pix;

  for (genvar k = 0; k < KERNEL_WIDTH; k++) begin : g_row
    logic [ROW_W:0]   row_sum, row_off;
    logic [ROW_W-1:0] row_sel;

    assign row_sum = (ROW_W+1)'(out_row_r) + (ROW_W+1)'(k);
    assign row_off = row_sum - (ROW_W+1)'(HALF);
    always_comb begin
      if (row_sum < (ROW_W+1)'(HALF)) row_sel = '0;
      else if (row_off > (ROW_W+1)'(hm1)) row_sel = hm1;
      else row_sel = row_off[ROW_W-1:0];
    end
    assign col_pix[k] = bank_q[row_sel[SLOT_W-1:0]];
  end

  // Tag of the column, aligned with the read data.
  gbr_tag_t rd_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r.valid <= (state_r == S_READ);
      rd_tag_r.first <= (dc_cnt_r == '0);
      rd_tag_r.last  <= (dc_cnt_r == DC_W'(KERNEL_WIDTH - 1));
      rd_tag_r.dc    <= dc_cnt_r;
    end
  end

  // Chain of row cells forming the vertical sum.
  gbr_pix_t [KERNEL_WIDTH-1:0] chain_pix [KERNEL_WIDTH];
  gbr_csum_t                   chain_sum [KERNEL_WIDTH+1];
  gbr_tag_t                    chain_tag [KERNEL_WIDTH+1];

  assign chain_pix[0] = col_pix;
  assign chain_sum[0] = '0;
  assign chain_tag[0] = rd_tag_r;

  for (genvar k = 0; k < KERNEL_WIDTH; k++) begin : g_cell
    localparam int WI = (k >= HALF) ? k - HALF : HALF - k;
    if (k < KERNEL_WIDTH - 1) begin : g_mid
      gbr_tap_cell #(.KERNEL_WIDTH(KERNEL_WIDTH), .TAP(k)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .weight (weights_r[WI]),
        .pix_i  (chain_pix[k]),
        .sum_i  (chain_sum[k]),
        .tag_i  (chain_tag[k]),
        .pix_o  (chain_pix[k+1]),
        .sum_o  (chain_sum[k+1]),
        .tag_o  (chain_tag[k+1])
      );
    end else begin : g_end
      gbr_tap_cell #(.KERNEL_WIDTH(KERNEL_WIDTH), .TAP(k)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .weight (weights_r[WI]),
        .pix_i  (chain_pix[k]),
        .sum_i  (chain_sum[k]),
        .tag_i  (chain_tag[k]),
        .pix_o  (),
        .sum_o  (chain_sum[k+1]),
        .tag_o  (chain_tag[k+1])
      );
    end
  end

  // Horizontal weighting and accumulation.
  gbr_col_acc #(.KERNEL_WIDTH(KERNEL_WIDTH)) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .weights (weights_r),
    .sum_i   (chain_sum[KERNEL_WIDTH]),
    .tag_i   (chain_tag[KERNEL_WIDTH]),
    .done    (acc_done),
    .red     (acc_red),
    .green   (acc_green),
    .blue    (acc_blue)
  );

  // A finished kernel only arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> (state_r == S_WAIT))
    else $error("kernel result arrived outside the wait state");

  // No result position advances before the input has covered the lag.
  a_out_before_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (p_r < lag) |-> ((out_row_r == '0) && (out_col_r == '0)))
    else $error("result position moved before the first result");

  // The last result of a frame returns the raster position to the start.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_now) |=> ((p_r == '0) && (in_row_r == '0)))
    else $error("frame did not restart after its last result");

endmodule

[hdl/gbr_row_store.sv]
// ----------------------------------------------------------------------------
// gbr_row_store
// Ring of recent image rows, one memory bank per row slot.
// ----------------------------------------------------------------------------
module gbr_row_store import gbr_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [SLOT_W-1:0]      wr_slot,
  input  logic [AW-1:0]          wr_col,
  input  gbr_pix_t               wr_data,
  input  logic [AW-1:0]          rd_col,
  output gbr_pix_t [SLOTS-1:0]   rd_data
);

  // Every bank is read at the same column; the caller picks the rows it needs.
  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    gbr_pix_t bank_mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_slot == SLOT_W'(s))) begin
        bank_mem[wr_col] <= wr_data;
      end
      rd_data[s] <= bank_mem[rd_col];
    end
  end

endmodule

[hdl/gbr_tap_cell.sv]
// ----------------------------------------------------------------------------
// gbr_tap_cell
// One kernel row of the vertical filter: adds its weighted pixel to the sum.
// ----------------------------------------------------------------------------
module gbr_tap_cell import gbr_pkg::*; #(
  parameter int KERNEL_WIDTH = 9,
  parameter int TAP = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [WEIGHT_W-1:0]             weight,
  input  gbr_pix_t [KERNEL_WIDTH-1:0]     pix_i,
  input  gbr_csum_t                       sum_i,
  input  gbr_tag_t                        tag_i,
  output gbr_pix_t [KERNEL_WIDTH-1:0]     pix_o,
  output gbr_csum_t                       sum_o,
  output gbr_tag_t                        tag_o
);

  gbr_pix_t [KERNEL_WIDTH-1:0] pix_r;
  gbr_csum_t                   sum_r, sum_nxt;
  gbr_tag_t                    tag_r;
  logic [23:0]                 prod_red, prod_green, prod_blue;

  // Weighted pixel of this row, added to the partial column sum.
  assign prod_red   = 24'(pix_i[TAP].red) * 24'(weight);
  assign prod_green = 24'(pix_i[TAP].green) * 24'(weight);
  assign prod_blue  = 24'(pix_i[TAP].blue) * 24'(weight);

  always_comb begin
    sum_nxt.red   = sum_i.red + CSUM_W'(prod_red);
    sum_nxt.green = sum_i.green + CSUM_W'(prod_green);
    sum_nxt.blue  = sum_i.blue + CSUM_W'(prod_blue);
  end

  // Hand the column on to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
    pix_r <= pix_i;
    sum_r <= sum_nxt;
  end

  assign pix_o = pix_r;
  assign sum_o = sum_r;
  assign tag_o = tag_r;

endmodule

[hdl/gbr_col_acc.sv]
// ----------------------------------------------------------------------------
// gbr_col_acc
// Horizontal filter: weights each column sum and accumulates the kernel.
// ----------------------------------------------------------------------------
module gbr_col_acc import gbr_pkg::*; #(
  parameter int KERNEL_WIDTH = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gbr_weights_t  weights,
  input  gbr_csum_t     sum_i,
  input  gbr_tag_t      tag_i,
  output logic          done,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue
);

  localparam int HALF = KERNEL_WIDTH / 2;

  logic [DC_W-1:0]     col_dist;
  logic [WEIGHT_W-1:0] wsel;
  logic [ACC_W-1:0]    prod_red_r, prod_green_r, prod_blue_r;
  logic [ACC_W-1:0]    acc_red_r, acc_green_r, acc_blue_r;
  gbr_tag_t            tag1_r;
  logic                done_r;

  // Weight of this column offset.
  assign col_dist = (tag_i.dc >= DC_W'(HALF)) ? tag_i.dc - DC_W'(HALF)
                                              : DC_W'(HALF) - tag_i.dc;
  assign wsel = weights[col_dist[WI_W-1:0]];

  // Multiply stage, then accumulate stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag1_r <= tag_i;
      done_r <= tag1_r.valid && tag1_r.last;
    end
    prod_red_r   <= ACC_W'(sum_i.red) * ACC_W'(wsel);
    prod_green_r <= ACC_W'(sum_i.green) * ACC_W'(wsel);
    prod_blue_r  <= ACC_W'(sum_i.blue) * ACC_W'(wsel);
    if (tag1_r.valid) begin
      acc_red_r   <= tag1_r.first ? prod_red_r : acc_red_r + prod_red_r;
      acc_green_r <= tag1_r.first ? prod_green_r : acc_green_r + prod_green_r;
      acc_blue_r  <= tag1_r.first ? prod_blue_r : acc_blue_r + prod_blue_r;
    end
  end

  // Drop the fraction and saturate to a byte.
  function automatic logic [7:0] sat8(input logic [ACC_W-1:0] acc);
    logic [ACC_W-FRAC_W-1:0] whole;
    whole = acc[ACC_W-1:FRAC_W];
    return (|whole[ACC_W-FRAC_W-1:8]) ? 8'hFF : whole[7:0];
  endfunction

  assign done  = done_r;
  assign red   = sat8(acc_red_r);
  assign green = sat8(acc_green_r);
  assign blue  = sat8(acc_blue_r);

endmodule

[bench/gbr_chk.sv]
// ----------------------------------------------------------------------------
// gbr_chk
// Watches the pixel, result and register ports of the 9x9 RGB blur, keeps
// its own model of the line store and raster counters, predicts each
// blurred pixel and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module gbr_chk import gbr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  gbr_in_if                  in_mon,
  gbr_out_if                 out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 item_count,
  output int                 result_count,
  output int                 frame_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF      = 4;
  localparam int MAXW      = 2048;
  localparam int MAXH      = 2048;
  localparam int PIX_DEPTH = 2 * HALF * MAXW + 2 * HALF + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_res_t;

  gbr_pix_t          pix_store [PIX_DEPTH];
  int unsigned       col_in, row_in, col_out, row_out;
  logic [CFG_W-1:0]  width_reg, height_reg;
  gbr_weights_t      wt_reg;
  blur_res_t         blur_q [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    item_count   = 0;
    result_count = 0;
    frame_count  = 0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    wt_reg     = WEIGHT_RST;
  end

  // Zero and oversize frame dimensions are folded into the legal range.
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  // Drop the Q0.32 fraction and clip at full scale.
  function automatic logic [7:0] clip8(input logic [63:0] acc);
    logic [63:0] whole;
    whole = acc >> 32;
    return (whole > 255) ? 8'd255 : whole[7:0];
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Advance the raster model by one accepted item and queue any blurred pixel.
  task automatic blur_step(input logic drain, input gbr_pix_t px);
    int unsigned w, h, p, lag;
    bit          frame_in;
    logic [63:0] acc_r, acc_g, acc_b, wt2;
    int          rr, cc;
    gbr_pix_t    q;
    blur_res_t   res;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    frame_in = (row_in < h);
    acc_r = 0; acc_g = 0; acc_b = 0;
    // A drain while the frame still expects pixels does nothing.
    if (drain && frame_in) return;
    p = row_in * w + col_in;
    if (frame_in && !drain) pix_store[p % PIX_DEPTH] = px;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    lag = HALF * w + HALF;
    if (p < lag) return;
    for (int dr = -HALF; dr <= HALF; dr++) begin
      rr = int'(row_out) + dr;
      if (rr < 0) rr = 0;
      if (rr > int'(h) - 1) rr = int'(h) - 1;
      for (int dc = -HALF; dc <= HALF; dc++) begin
        cc = int'(col_out) + dc;
        if (cc < 0) cc = 0;
        if (cc > int'(w) - 1) cc = int'(w) - 1;
        q = pix_store[(rr * w + cc) % PIX_DEPTH];
        wt2 = 64'(wt_reg[dr < 0 ? -dr : dr]) * 64'(wt_reg[dc < 0 ? -dc : dc]);
        acc_r += 64'(q.red) * wt2;
        acc_g += 64'(q.green) * wt2;
        acc_b += 64'(q.blue) * wt2;
      end
    end
    res.red   = clip8(acc_r);
    res.green = clip8(acc_g);
    res.blue  = clip8(acc_b);
    res.last  = (row_out >= h - 1) && (col_out >= w - 1);
    blur_q.push_back(res);
    if (res.last) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endtask

  // Register writes, accepted pixel items and accepted results, in that order.
  always @(posedge clk) begin
    gbr_pix_t  px;
    blur_res_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (gbr_reg_t'(paddr[4:2]))
          REG_WIDTH: begin
            width_reg = pwdata[CFG_W-1:0];
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
          end
          REG_HEIGHT: begin
            height_reg = pwdata[CFG_W-1:0];
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
          end
          REG_WEIGHT0: wt_reg[0] = pwdata[WEIGHT_W-1:0];
          REG_WEIGHT1: wt_reg[1] = pwdata[WEIGHT_W-1:0];
          REG_WEIGHT2: wt_reg[2] = pwdata[WEIGHT_W-1:0];
          REG_WEIGHT3: wt_reg[3] = pwdata[WEIGHT_W-1:0];
          REG_WEIGHT4: wt_reg[4] = pwdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        px.red   = in_mon.in_red;
        px.green = in_mon.in_green;
        px.blue  = in_mon.in_blue;
        item_count++;
        blur_step(in_mon.action, px);
      end
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (blur_q.size() == 0) begin
          $display("%t blurred pixel arrived with none expected", $realtime);
          fail_count++;
        end else begin
          want = blur_q.pop_front();
          if (out_mon.out_red !== want.red) report("red", out_mon.out_red, want.red);
          if (out_mon.out_green !== want.green)
            report("green", out_mon.out_green, want.green);
          if (out_mon.out_blue !== want.blue) report("blue", out_mon.out_blue, want.blue);
          if (out_mon.frame_last !== want.last)
            report("frame_last", out_mon.frame_last, want.last);
          if (want.last) frame_count++;
        end
      end
      pending = blur_q.size();
    end
  end
endmodule

[bench/gaussian_blur_rgb_9x9_tb.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_9x9_tb
// Drives frames of random RGB pixels and drain items through the blur under
// several sizes and weight sets, with bursty input and a stalling receiver;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb_9x9_tb;
  import gbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam int   HALF      = 4;
  localparam int   SETTLE    = 40;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int                 fail_count, pending, item_count, result_count, frame_count;
  int                 items_sent;
  int                 burst_left;
  rx_mode_t           rx_mode;
  int                 rx_left;

  gbr_in_if  in_ch ();
  gbr_out_if out_ch ();

  gaussian_blur_rgb_9x9 dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gbr_chk chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
    .item_count(item_count), .result_count(result_count), .frame_count(frame_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("gaussian_blur_rgb_9x9 regression: fail");
    $finish;
  end

  // Receiver: switches between always ready, coin-flip ready and rare ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode <= RX_OPEN;
      rx_left <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Send one item, pausing between bursts of random length.
  task automatic push(input logic act, input logic [23:0] rgb);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.in_red   <= rgb[23:16];
    in_ch.in_green <= rgb[15:8];
    in_ch.in_blue  <= rgb[7:0];
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Let all expected results come out, then give the pipeline time to settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input gbr_reg_t idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_weights(input logic [15:0] w0, w1, w2, w3, w4);
    reg_write(REG_WEIGHT0, PDATA_W'(w0));
    reg_write(REG_WEIGHT1, PDATA_W'(w1));
    reg_write(REG_WEIGHT2, PDATA_W'(w2));
    reg_write(REG_WEIGHT3, PDATA_W'(w3));
    reg_write(REG_WEIGHT4, PDATA_W'(w4));
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // One whole frame: its pixels with stray drains, then the drains that
  // release the tail, some of them replaced by pixels the block must drop.
  task automatic run_frame(input int w, input int h, input bit noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) push(ACT_DRAIN, 24'($urandom));
      push(ACT_PIXEL, 24'($urandom));
    end
    for (int i = 0; i < HALF * w + HALF; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) push(ACT_PIXEL, 24'($urandom));
      else push(ACT_DRAIN, 24'($urandom));
    end
    // Drains after the frame end fall into the next frame and are ignored.
    if (noisy) repeat ($urandom_range(0, 2)) push(ACT_DRAIN, 24'($urandom));
    wait_idle();
  endtask

  initial begin
    int w, h;
    rst_n          = 1'b0;
    burst_left     = 0;
    items_sent     = 0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_PIXEL;
    in_ch.in_red   <= '0;
    in_ch.in_green <= '0;
    in_ch.in_blue  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Single-pixel frame with full-scale weights: the sum saturates.
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    reg_write(REG_WIDTH, 1);
    reg_write(REG_HEIGHT, 1);
    push(ACT_DRAIN, 24'h123456);
    push(ACT_PIXEL, 24'hFF0080);
    push(ACT_PIXEL, 24'h00FF7F);
    repeat (7) push(ACT_DRAIN, 24'h0);
    wait_idle();

    // Zero sizes act as one; zero weights give black.
    set_weights(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    reg_write(REG_WIDTH, 0);
    reg_write(REG_HEIGHT, 0);
    run_frame(1, 1, 1'b0);

    // A size write in the middle of a frame starts the frame over.
    set_weights(16'd13376, 16'd11810, 16'd8116, 16'd4344, 16'd1810);
    reg_write(REG_WIDTH, 5);
    reg_write(REG_HEIGHT, 5);
    repeat (3) push(ACT_PIXEL, 24'($urandom));
    wait_idle();
    reg_write(REG_WIDTH, 3);
    reg_write(REG_HEIGHT, 3);
    run_frame(3, 3, 1'b0);

    // Oversize width clips to the widest row, so the lag is far off and
    // a short start of the frame gives no result.
    set_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight(), pick_weight());
    reg_write(REG_WIDTH, 32'hFFF);
    reg_write(REG_HEIGHT, 1);
    repeat (20) push(ACT_PIXEL, 24'($urandom));
    wait_idle();

    // Oversize height on a one-pixel-wide frame: the top of a tall column.
    reg_write(REG_WIDTH, 1);
    reg_write(REG_HEIGHT, 32'hFFF);
    repeat (200) push(ACT_PIXEL, 24'($urandom));
    wait_idle();

    // Random frames, mostly small, under random weight sets.
    while (items_sent < 1350) begin
      set_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight(), pick_weight());
      if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(13, 40);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end
      reg_write(REG_WIDTH, w);
      reg_write(REG_HEIGHT, h);
      run_frame(w, h, 1'b1);
    end

    wait_idle();
    $display("Run covered %0d accepted items and %0d blurred pixels over %0d frames.",
             item_count, result_count, frame_count);
    if (pending != 0) $display("%0d blurred pixels never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("gaussian_blur_rgb_9x9 regression: pass");
    end else begin
      $display("gaussian_blur_rgb_9x9 regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/gbr_pkg.sv
hdl/gbr_if.sv
hdl/gbr_row_store.sv
hdl/gbr_tap_cell.sv
hdl/gbr_col_acc.sv
hdl/gaussian_blur_rgb_9x9.sv
bench/gbr_chk.sv
bench/gaussian_blur_rgb_9x9_tb.sv
